FILE: hdl/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque message queue - shared definitions
// Request codes, status codes, field widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Default build sizes
    localparam int DEPTH_DEF     = 16;
    localparam int ITEM_BITS_DEF = 32;

    // Fixed field widths of the ports
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 5;   // capacity register, waiting and spaces fields

    // Largest count the capacity register can express
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Capacity after reset
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    // Request codes
    localparam logic [MODE_W-1:0] MODE_SEND_BACK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECEIVE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // Control for one storage cell
    typedef struct packed {
        logic load;       // take the incoming item
        logic from_left;  // take the neighbour towards the front
        logic from_right; // take the neighbour towards the back
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: hdl/bdq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque message queue - storage cell
// Holds one queue entry; loads a new item or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module bdq_cell #(
    parameter int ITEM_BITS = bdq_pkg::ITEM_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire bdq_pkg::t_cell_ctl i_ctl,
    input  wire [ITEM_BITS-1:0]     i_item,
    input  wire [ITEM_BITS-1:0]     i_left,
    input  wire [ITEM_BITS-1:0]     i_right,
    output wire [ITEM_BITS-1:0]     o_entry
);

    logic [ITEM_BITS-1:0] r_entry;

    // Entry register: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_item;
        end else if (i_ctl.from_left) begin
            r_entry <= i_left;
        end else if (i_ctl.from_right) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

FILE: hdl/bounded_deque_message_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque message queue - top level
// Row of entry cells with the front at cell 0, request control and APB port.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: drive i_mode and i_item_data with i_start high; the transaction
//   is taken at a clock edge where i_start is high and o_busy is low. o_busy
//   is never raised, so one request can be issued every cycle.
//   Modes: send to back, send to front, receive front, peek front.
//   Results: one per request, on o_status, o_read_data, o_messages_waiting
//   and o_spaces_available, marked by o_valid for exactly one cycle, the
//   cycle after the request was taken (throughput 1 per cycle).
//   The cells are updated in the request cycle: a send to the front
//   moves every entry one cell back, a receive moves every entry one cell
//   towards the front, a send to the back loads the cell at the fill count.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Configuration: APB, capacity register at byte address 0, write only
//   while idle. pready is always high.
//   Reset (i_rst_n low, synchronous): queue empty, capacity 16, no result.
//   Entry contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_message_queue #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = bdq_pkg::ITEM_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Request channel
    input  wire                          i_start,
    output wire                          o_busy,
    input  wire [bdq_pkg::MODE_W-1:0]    i_mode,
    input  wire [bdq_pkg::DATA_W-1:0]    i_item_data,
    // Result channel
    output wire                          o_valid,
    output wire [bdq_pkg::STATUS_W-1:0]  o_status,
    output wire [bdq_pkg::DATA_W-1:0]    o_read_data,
    output wire [bdq_pkg::CNT_W-1:0]     o_messages_waiting,
    output wire [bdq_pkg::CNT_W-1:0]     o_spaces_available,
    // Configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [2:0]                    paddr,
    input  wire [31:0]                   pwdata,
    output wire [31:0]                   prdata,
    output wire                          pready
);

    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int DW    = bdq_pkg::DATA_W;
    // Effective capacity never exceeds the built depth
    localparam int                CAP_LIM_I = (DEPTH > bdq_pkg::CNT_MAX) ?
                                              bdq_pkg::CNT_MAX : DEPTH;
    localparam logic [CNT_W-1:0]  CAP_LIM   = CNT_W'(CAP_LIM_I);

    logic [CNT_W-1:0]             r_cap;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_valid;
    logic [bdq_pkg::STATUS_W-1:0] r_status;
    logic [bdq_pkg::STATUS_W-1:0] n_status;
    logic [DW-1:0]                r_read_data;
    logic [DW-1:0]                n_read_data;
    logic [CNT_W-1:0]             r_waiting;
    logic [CNT_W-1:0]             r_spaces;
    logic [CNT_W-1:0]             n_spaces;

    logic [CNT_W-1:0]             w_cap_eff;
    logic                         w_go;
    logic                         w_send;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_ins_back;
    logic                         w_ins_front;
    logic                         w_pop;
    logic                         w_cfg_wr;
    logic [ITEM_BITS-1:0]         w_item;
    logic [DW-1:0]                w_front;
    logic [ITEM_BITS-1:0]         w_entry [DEPTH];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == bdq_pkg::REG_CAPACITY);
    assign prdata   = (paddr[2] == bdq_pkg::REG_CAPACITY) ?
                      {{(32-CNT_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bdq_pkg::CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Item width conversion between port and cells
    // ------------------------------------------------------------------
    generate
        if (ITEM_BITS == DW) begin : g_same
            assign w_item  = i_item_data;
            assign w_front = w_entry[0];
        end else if (ITEM_BITS > DW) begin : g_wide
            assign w_item  = {{(ITEM_BITS-DW){1'b0}}, i_item_data};
            assign w_front = w_entry[0][DW-1:0];
        end else begin : g_narrow
            assign w_item  = i_item_data[ITEM_BITS-1:0];
            assign w_front = {{(DW-ITEM_BITS){1'b0}}, w_entry[0]};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign o_busy      = 1'b0;
    assign w_go        = i_start && !o_busy;
    assign w_cap_eff   = (r_cap > CAP_LIM) ? CAP_LIM : r_cap;
    assign w_send      = (i_mode == bdq_pkg::MODE_SEND_BACK) ||
                         (i_mode == bdq_pkg::MODE_SEND_FRONT);
    assign w_full      = (r_count >= w_cap_eff);
    assign w_empty     = (r_count == '0);
    assign w_ins_back  = w_go && (i_mode == bdq_pkg::MODE_SEND_BACK) && !w_full;
    assign w_ins_front = w_go && (i_mode == bdq_pkg::MODE_SEND_FRONT) && !w_full;
    assign w_pop       = w_go && (i_mode == bdq_pkg::MODE_RECEIVE) && !w_empty;

    // Status, read data, next count and spaces
    always_comb begin
        n_status    = bdq_pkg::ST_DONE;
        n_read_data = '0;
        n_count     = r_count;
        if (w_send) begin
            if (w_full) begin
                n_status = bdq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_empty) begin
            n_status = bdq_pkg::ST_EMPTY;
        end else begin
            n_read_data = w_front;
            if (i_mode == bdq_pkg::MODE_RECEIVE) begin
                n_count = r_count - CNT_W'(1);
            end
        end
        n_spaces = (w_cap_eff > n_count) ? (w_cap_eff - n_count) : '0;
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_go) begin
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Row of cells, front at cell 0
    // ------------------------------------------------------------------
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            bdq_pkg::t_cell_ctl   w_ctl;
            logic [ITEM_BITS-1:0] w_left;
            logic [ITEM_BITS-1:0] w_right;

            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == DEPTH-1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end

            always_comb begin
                w_ctl.load       = (w_ins_back && (int'(r_count) == gi)) ||
                                   (w_ins_front && (gi == 0));
                w_ctl.from_left  = w_ins_front && (gi != 0);
                w_ctl.from_right = w_pop;
            end

            bdq_cell #(
                .ITEM_BITS (ITEM_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_item  (w_item),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_status    <= n_status;
            r_read_data <= n_read_data;
            r_waiting   <= n_count;
            r_spaces    <= n_spaces;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_read_data        = r_read_data;
    assign o_messages_waiting = r_waiting;
    assign o_spaces_available = r_spaces;

endmodule
`default_nettype wire
